### design/jsu_pkg.sv
package jsu_pkg;

    localparam int JSU_QDEPTH = 4;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_EXP_QUOTE   = 4'd1;
    localparam logic [3:0] ERR_CTRL_CHAR   = 4'd2;
    localparam logic [3:0] ERR_TRUNC_ESC   = 4'd3;
    localparam logic [3:0] ERR_BAD_ESC     = 4'd4;
    localparam logic [3:0] ERR_TRUNC_UNI   = 4'd5;
    localparam logic [3:0] ERR_BAD_HEX     = 4'd6;
    localparam logic [3:0] ERR_SURROGATE   = 4'd7;
    localparam logic [3:0] ERR_UNTERM      = 4'd8;

    // one decoded command: up to three results of the same kind
    typedef struct packed {
        logic [1:0] n_res;
        logic [1:0] kind;
        logic [3:0] err;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_cmd;

endpackage

### design/jsu_front.sv
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_func,
    input  logic [7:0]    i_in_byte,
    output logic          o_cmd_valid,
    output jsu_pkg::t_cmd o_cmd
);
    import jsu_pkg::*;

    localparam logic [2:0] PH_QUOTE  = 3'd0;
    localparam logic [2:0] PH_STRING = 3'd1;
    localparam logic [2:0] PH_ESCAPE = 3'd2;
    localparam logic [2:0] PH_HEX    = 3'd3;
    localparam logic [2:0] PH_HALT   = 3'd4;

    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_digits, n_digits;
    logic [15:0] r_accum, n_accum;

    logic        w_hex_ok;
    logic [3:0]  w_hex_val;
    logic [15:0] w_code;
    logic        w_valid;
    t_cmd        w_cmd;

    always_comb begin
        w_hex_ok  = 1'b1;
        w_hex_val = 4'd0;
        if (i_in_byte inside {[8'h30:8'h39]}) begin
            w_hex_val = i_in_byte[3:0];
        end else if (i_in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            w_hex_val = 4'(i_in_byte[2:0] + 3'd1) + 4'd8;
        end else begin
            w_hex_ok = 1'b0;
        end
    end

    assign w_code = {r_accum[11:0], w_hex_val};

    always_comb begin
        n_phase  = r_phase;
        n_digits = r_digits;
        n_accum  = r_accum;
        w_valid  = 1'b0;
        w_cmd    = '{n_res: 2'd1, kind: KIND_BYTE, err: ERR_NONE,
                     b0: 8'd0, b1: 8'd0, b2: 8'd0};
        if (i_func) begin
            n_phase  = PH_QUOTE;
            n_digits = 2'd0;
            n_accum  = 16'd0;
            w_cmd.kind = KIND_ERROR;
            case (r_phase)
                PH_STRING: begin w_valid = 1'b1; w_cmd.err = ERR_UNTERM;    end
                PH_ESCAPE: begin w_valid = 1'b1; w_cmd.err = ERR_TRUNC_ESC; end
                PH_HEX:    begin w_valid = 1'b1; w_cmd.err = ERR_TRUNC_UNI; end
                default:   w_valid = 1'b0;
            endcase
        end else begin
            case (r_phase)
                PH_QUOTE: begin
                    if (i_in_byte == 8'h22) begin
                        n_phase = PH_STRING;
                    end else begin
                        n_phase    = PH_HALT;
                        w_valid    = 1'b1;
                        w_cmd.kind = KIND_ERROR;
                        w_cmd.err  = ERR_EXP_QUOTE;
                    end
                end
                PH_STRING: begin
                    w_valid = 1'b1;
                    if (i_in_byte == 8'h22) begin
                        n_phase    = PH_QUOTE;
                        w_cmd.kind = KIND_CLOSE;
                    end else if (i_in_byte < 8'h20) begin
                        n_phase    = PH_HALT;
                        w_cmd.kind = KIND_ERROR;
                        w_cmd.err  = ERR_CTRL_CHAR;
                    end else if (i_in_byte == 8'h5C) begin
                        n_phase = PH_ESCAPE;
                        w_valid = 1'b0;
                    end else begin
                        w_cmd.b0 = i_in_byte;
                    end
                end
                PH_ESCAPE: begin
                    w_valid = 1'b1;
                    n_phase = PH_STRING;
                    case (i_in_byte)
                        8'h22:   w_cmd.b0 = 8'h22;
                        8'h5C:   w_cmd.b0 = 8'h5C;
                        8'h2F:   w_cmd.b0 = 8'h2F;
                        8'h62:   w_cmd.b0 = 8'h08;
                        8'h66:   w_cmd.b0 = 8'h0C;
                        8'h6E:   w_cmd.b0 = 8'h0A;
                        8'h72:   w_cmd.b0 = 8'h0D;
                        8'h74:   w_cmd.b0 = 8'h09;
                        8'h75: begin
                            w_valid  = 1'b0;
                            n_phase  = PH_HEX;
                            n_digits = 2'd0;
                            n_accum  = 16'd0;
                        end
                        default: begin
                            n_phase    = PH_HALT;
                            w_cmd.kind = KIND_ERROR;
                            w_cmd.err  = ERR_BAD_ESC;
                        end
                    endcase
                end
                PH_HEX: begin
                    if (!w_hex_ok) begin
                        n_phase    = PH_HALT;
                        n_digits   = 2'd0;
                        n_accum    = 16'd0;
                        w_valid    = 1'b1;
                        w_cmd.kind = KIND_ERROR;
                        w_cmd.err  = ERR_BAD_HEX;
                    end else if (r_digits != 2'd3) begin
                        n_digits = r_digits + 2'd1;
                        n_accum  = w_code;
                    end else begin
                        n_digits = 2'd0;
                        n_accum  = 16'd0;
                        w_valid  = 1'b1;
                        n_phase  = PH_STRING;
                        if (w_code[15:11] == 5'b11011) begin
                            n_phase    = PH_HALT;
                            w_cmd.kind = KIND_ERROR;
                            w_cmd.err  = ERR_SURROGATE;
                        end else if (w_code[15:7] == 9'd0) begin
                            w_cmd.b0 = w_code[7:0];
                        end else if (w_code[15:11] == 5'd0) begin
                            w_cmd.n_res = 2'd2;
                            w_cmd.b0    = {3'b110, w_code[10:6]};
                            w_cmd.b1    = {2'b10, w_code[5:0]};
                        end else begin
                            w_cmd.n_res = 2'd3;
                            w_cmd.b0    = {4'b1110, w_code[15:12]};
                            w_cmd.b1    = {2'b10, w_code[11:6]};
                            w_cmd.b2    = {2'b10, w_code[5:0]};
                        end
                    end
                end
                default: w_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_QUOTE;
            r_digits <= 2'd0;
            r_accum  <= 16'd0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_digits <= n_digits;
            r_accum  <= n_accum;
        end
    end

    assign o_cmd_valid = i_accept && w_valid;
    assign o_cmd       = w_cmd;

endmodule

### design/jsu_fifo.sv
module jsu_fifo #(
    parameter int DEPTH = jsu_pkg::JSU_QDEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_cmd i_data,
    input  logic          i_pop,
    output jsu_pkg::t_cmd o_data,
    output logic          o_full,
    output logic          o_empty
);
    import jsu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/jsu_back.sv
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  jsu_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [1:0]    o_out_kind,
    output logic [7:0]    o_out_byte,
    output logic [3:0]    o_error_code,
    output logic          o_last
);
    import jsu_pkg::*;

    logic       r_valid;
    logic [1:0] r_idx;
    logic [1:0] r_kind;
    logic [7:0] r_byte;
    logic [3:0] r_err;
    logic       r_last;

    logic       w_load;
    logic       w_take;
    logic       w_is_last;
    logic [7:0] w_byte;

    assign w_load    = !r_valid || i_pop;
    assign w_take    = w_load && i_cmd_valid;
    assign w_is_last = (r_idx == i_cmd.n_res - 2'd1);
    assign o_cmd_pop = w_take && w_is_last;

    always_comb begin
        case (r_idx)
            2'd0:    w_byte = i_cmd.b0;
            2'd1:    w_byte = i_cmd.b1;
            default: w_byte = i_cmd.b2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_kind <= i_cmd.kind;
            r_byte <= w_byte;
            r_err  <= i_cmd.err;
            r_last <= w_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (w_load) begin
                r_valid <= i_cmd_valid;
            end
            if (w_take) begin
                r_idx <= w_is_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    assign o_empty      = !r_valid;
    assign o_out_kind   = r_kind;
    assign o_out_byte   = r_byte;
    assign o_error_code = r_err;
    assign o_last       = r_last;

endmodule

### design/json_string_unescape.sv
// Streaming decoder for quoted JSON string literals. One input item (a byte, or an
// end-of-input mark on i_func) is taken per clock while full is low; the front end
// decodes it in the cycle it is accepted and queues a command of one to three
// results, or none. Results leave one per cycle while pop is high, from an output
// register; each command passes through the queue and then that output register
// before the first result of an item is visible. A \u escape that encodes to two or
// three UTF-8 bytes holds the output side while each of its bytes leaves; the command
// queue (QDEPTH entries) absorbs that, and full rises only when it fills. After an
// error, data bytes are dropped until an end-of-input item arrives.
module json_string_unescape #(
    parameter int QDEPTH = jsu_pkg::JSU_QDEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_func,
    input  logic [7:0] i_in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_byte,
    output logic [3:0] o_error_code,
    output logic       o_last
);
    import jsu_pkg::*;

    logic w_accept;
    logic w_cmd_valid;
    t_cmd w_cmd;
    t_cmd w_head;
    logic w_q_empty;
    logic w_q_pop;

    assign w_accept = push && !full;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_func      (i_func),
        .i_in_byte   (i_in_byte),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    jsu_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_valid),
        .i_data  (w_cmd),
        .i_pop   (w_q_pop),
        .o_data  (w_head),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (!w_q_empty),
        .i_cmd        (w_head),
        .o_cmd_pop    (w_q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_kind   (o_out_kind),
        .o_out_byte   (o_out_byte),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_kind == KIND_ERROR) |-> o_last)
        else $error("error result not marked last");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_kind != KIND_BYTE) |-> (o_out_byte == 8'd0))
        else $error("nonzero byte on non-byte result");

    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_kind != KIND_ERROR) |-> (o_error_code == ERR_NONE))
        else $error("error code on non-error result");

    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_kind == KIND_CLOSE) |-> o_last)
        else $error("close result not marked last");

endmodule

### tb/tb_json_string_unescape.sv
`timescale 1ns / 100ps

module tb_json_string_unescape;
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0]  ESC_LIST [8] = '{8'h22, 8'h5C, 8'h2F, "b", "f", "n", "r", "t"};
    localparam logic [15:0] CP_EDGES [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                             16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

    typedef enum logic [2:0] {S_QUOTE, S_STR, S_ESC, S_HEX, S_HALT} t_scan;

    typedef struct packed {
        logic       fn;
        logic [7:0] data;
    } t_stim;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] err;
        logic       last;
    } t_dec;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       push      = 1'b0;
    logic       i_func    = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       pop       = 1'b0;
    logic       full;
    logic       empty;
    logic [1:0] o_out_kind;
    logic [7:0] o_out_byte;
    logic [3:0] o_error_code;
    logic       o_last;

    t_stim pending_q [$];
    t_dec  decoded_q [$];
    t_stim nxt_item;
    t_dec  want;

    int queued_total = 0;
    int err_cnt      = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_left    = 0;
    bit hold_req     = 1'b0;

    t_scan       scan_st  = S_QUOTE;
    logic [1:0]  hex_cnt  = 2'd0;
    logic [15:0] code_acc = 16'h0000;
    t_dec        step_res [3];
    int          step_n;

    json_string_unescape u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_func       (i_func),
        .i_in_byte    (i_in_byte),
        .empty        (empty),
        .pop          (pop),
        .o_out_kind   (o_out_kind),
        .o_out_byte   (o_out_byte),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int hex_val(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    // {valid, decoded byte} for a single-letter escape
    function automatic logic [8:0] esc_byte(logic [7:0] c);
        case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: return {1'b1, c};
            "b": return {1'b1, 8'h08};
            "f": return {1'b1, 8'h0C};
            "n": return {1'b1, 8'h0A};
            "r": return {1'b1, 8'h0D};
            "t": return {1'b1, 8'h09};
            default: return 9'h000;
        endcase
    endfunction

    // ---------------- expected decoder output ----------------

    task automatic add_res(input logic [1:0] kind, input logic [7:0] b, input logic [3:0] e);
        step_res[step_n] = '{kind, b, e, 1'b0};
        step_n++;
    endtask

    task automatic halt_on(input logic [3:0] e);
        scan_st  = S_HALT;
        hex_cnt  = 2'd0;
        code_acc = 16'h0000;
        add_res(KIND_ERROR, 8'h00, e);
    endtask

    task automatic decode_item(input logic fn, input logic [7:0] c);
        logic [3:0]  e;
        logic [8:0]  m;
        logic [15:0] v;
        int          d;
        step_n = 0;
        if (fn) begin
            case (scan_st)
                S_STR:   e = ERR_UNTERM;
                S_ESC:   e = ERR_TRUNC_ESC;
                S_HEX:   e = ERR_TRUNC_UNI;
                default: e = ERR_NONE;
            endcase
            scan_st  = S_QUOTE;
            hex_cnt  = 2'd0;
            code_acc = 16'h0000;
            if (e != ERR_NONE) add_res(KIND_ERROR, 8'h00, e);
        end else begin
            case (scan_st)
                S_QUOTE: begin
                    if (c == CH_QUOTE) scan_st = S_STR;
                    else halt_on(ERR_EXP_QUOTE);
                end
                S_STR: begin
                    if (c == CH_QUOTE) begin
                        scan_st = S_QUOTE;
                        add_res(KIND_CLOSE, 8'h00, ERR_NONE);
                    end else if (c < 8'h20) begin
                        halt_on(ERR_CTRL_CHAR);
                    end else if (c == CH_BSLASH) begin
                        scan_st = S_ESC;
                    end else begin
                        add_res(KIND_BYTE, c, ERR_NONE);
                    end
                end
                S_ESC: begin
                    m = esc_byte(c);
                    if (c == CH_U) begin
                        scan_st  = S_HEX;
                        hex_cnt  = 2'd0;
                        code_acc = 16'h0000;
                    end else if (m[8]) begin
                        scan_st = S_STR;
                        add_res(KIND_BYTE, m[7:0], ERR_NONE);
                    end else begin
                        halt_on(ERR_BAD_ESC);
                    end
                end
                S_HEX: begin
                    d = hex_val(c);
                    if (d < 0) begin
                        halt_on(ERR_BAD_HEX);
                    end else begin
                        code_acc = {code_acc[11:0], 4'(d)};
                        if (hex_cnt < 2'd3) begin
                            hex_cnt++;
                        end else begin
                            v        = code_acc;
                            hex_cnt  = 2'd0;
                            code_acc = 16'h0000;
                            if (v >= 16'hD800 && v <= 16'hDFFF) begin
                                halt_on(ERR_SURROGATE);
                            end else begin
                                scan_st = S_STR;
                                if (v <= 16'h007F) begin
                                    add_res(KIND_BYTE, v[7:0], ERR_NONE);
                                end else if (v <= 16'h07FF) begin
                                    add_res(KIND_BYTE, {3'b110, v[10:6]}, ERR_NONE);
                                    add_res(KIND_BYTE, {2'b10, v[5:0]}, ERR_NONE);
                                end else begin
                                    add_res(KIND_BYTE, {4'b1110, v[15:12]}, ERR_NONE);
                                    add_res(KIND_BYTE, {2'b10, v[11:6]}, ERR_NONE);
                                    add_res(KIND_BYTE, {2'b10, v[5:0]}, ERR_NONE);
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (step_n > 0) step_res[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++) decoded_q.insert(decoded_q.size(), step_res[i]);
    endtask

    // ---------------- stimulus ----------------

    task automatic put_item(input logic fn, input logic [7:0] b);
        pending_q.insert(pending_q.size(), '{fn: fn, data: b});
        queued_total++;
    endtask

    task automatic put_eoi();
        put_item(1'b1, 8'($urandom));
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [15:0] rand_code();
        case ($urandom_range(4))
            0:       return 16'($urandom_range(16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
            3:       return 16'($urandom_range(16'hE000, 16'hFFFF));
            default: return CP_EDGES[$urandom_range(7)];
        endcase
    endfunction

    // backslash, u, then the first ndig hex digits of cp
    task automatic put_uni(input logic [15:0] cp, input int ndig);
        put_item(1'b0, CH_BSLASH);
        put_item(1'b0, CH_U);
        for (int i = 0; i < ndig; i++) put_item(1'b0, hex_char(cp[(3 - i) * 4 +: 4]));
    endtask

    task automatic put_unit();
        logic [7:0] b;
        int         sel;
        sel = $urandom_range(9);
        if (sel < 5) begin
            do b = 8'($urandom_range(8'h20, 8'hFF));
            while (b == CH_QUOTE || b == CH_BSLASH);
            put_item(1'b0, b);
        end else if (sel < 7) begin
            put_item(1'b0, CH_BSLASH);
            put_item(1'b0, ESC_LIST[$urandom_range(7)]);
        end else begin
            put_uni(rand_code(), 4);
        end
    endtask

    task automatic put_string();
        put_item(1'b0, CH_QUOTE);
        repeat ($urandom_range(6)) put_unit();
        put_item(1'b0, CH_QUOTE);
    endtask

    task automatic put_fault();
        logic [7:0] b;
        logic [8:0] m;
        int         sel;
        put_item(1'b0, CH_QUOTE);
        repeat ($urandom_range(3)) put_unit();
        sel = $urandom_range(7);
        case (sel)
            0: put_item(1'b0, 8'($urandom_range(8'h1F)));
            1: begin
                do begin
                    b = 8'($urandom);
                    m = esc_byte(b);
                end while (m[8] || b == CH_U);
                put_item(1'b0, CH_BSLASH);
                put_item(1'b0, b);
            end
            2: begin
                put_uni(rand_code(), $urandom_range(3));
                do b = 8'($urandom);
                while (hex_val(b) >= 0);
                put_item(1'b0, b);
            end
            3: put_uni(16'($urandom_range(16'hD800, 16'hDFFF)), 4);
            4: ;
            5: put_item(1'b0, CH_BSLASH);
            6: put_uni(rand_code(), $urandom_range(3));
            default: begin
                put_item(1'b0, CH_QUOTE);
                do b = 8'($urandom);
                while (b == CH_QUOTE);
                put_item(1'b0, b);
            end
        endcase
        // truncation cases need end of input right behind them
        if (sel < 4 || sel > 6) repeat ($urandom_range(2)) put_item(1'b0, 8'($urandom));
        put_eoi();
    endtask

    task automatic put_noise();
        repeat ($urandom_range(1, 4)) put_item($urandom_range(3) == 0, 8'($urandom));
        put_eoi();
    endtask

    task automatic gen_mix(input int count);
        int stop_at;
        stop_at = queued_total + count;
        while (queued_total < stop_at) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    put_string();
                    if ($urandom_range(2) == 0) put_eoi();
                end
                6, 7, 8: put_fault();
                default: put_noise();
            endcase
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || push || decoded_q.size() != 0);
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push     <= 1'b0;
            scan_st  = S_QUOTE;
            hex_cnt  = 2'd0;
            code_acc = 16'h0000;
        end else begin
            if (push && !full) decode_item(i_func, i_in_byte);
            if (!push || !full) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt_item = pending_q.pop_front();
                    push      <= 1'b1;
                    i_func    <= nxt_item.fn;
                    i_in_byte <= nxt_item.data;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (decoded_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: expected no item, actual kind=%0d byte=%h err=%0d last=%b",
                             $time, o_out_kind, o_out_byte, o_error_code, o_last);
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_kind !== want.kind || o_out_byte !== want.data ||
                        o_error_code !== want.err || o_last !== want.last) begin
                        err_cnt++;
                        $display("%0t: expected kind=%0d byte=%h err=%0d last=%b,",
                                 $time, want.kind, want.data, want.err, want.last,
                                 " actual kind=%0d byte=%h err=%0d last=%b",
                                 o_out_kind, o_out_byte, o_error_code, o_last);
                    end
                end
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle_pct = 19;
        rx_idle_pct = 68;

        put_item(1'b1, 8'hFF);                      // end of input between literals
        put_item(1'b0, CH_QUOTE);
        put_item(1'b0, 8'hFF);
        put_uni(16'hFFFF, 4);
        put_item(1'b0, CH_QUOTE);
        put_item(1'b0, "x");                        // expected quote
        put_item(1'b0, 8'h00);                      // dropped while halted
        put_item(1'b1, 8'h00);
        put_item(1'b0, CH_QUOTE);
        put_item(1'b0, 8'h1F);                      // control byte
        put_item(1'b1, 8'h5A);
        put_item(1'b0, CH_QUOTE);
        put_uni(16'hD800, 4);                       // surrogate
        put_item(1'b1, 8'hA5);
        put_item(1'b0, CH_QUOTE);
        put_item(1'b0, 8'h20);
        put_item(1'b1, 8'h01);                      // unterminated

        gen_mix(140);
        wait_drained();

        tx_idle_pct = 68;
        rx_idle_pct = 19;
        gen_mix(140);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;                         // long receiver stall, queue fills
        gen_mix(140);
        wait_drained();

        repeat (20) @(negedge i_clk);
        if (err_cnt == 0 && decoded_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
